// File: rtl/fssp_pkg.sv
// Shared types and constants for the Fitch state-set pass unit.
package fssp_pkg;

  // Pass codes carried in the kind field
  localparam logic [2:0] KIND_DOWN        = 3'd0;
  localparam logic [2:0] KIND_UP          = 3'd1;
  localparam logic [2:0] KIND_NA_FIRST_DN = 3'd2;
  localparam logic [2:0] KIND_NA_FIRST_UP = 3'd3;
  localparam logic [2:0] KIND_NA_SECOND_DN = 3'd4;
  localparam logic [2:0] KIND_NA_SECOND_UP = 3'd5;

  // Configuration register indexes
  localparam logic REG_NA_MASK = 1'b0;

  // Saturation limit of the step total
  localparam logic [30:0] TOTAL_MAX = 31'h7FFF_FFFF;

  // Captured input transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] left_set;
    logic [31:0] right_set;
    logic [31:0] node_set;
    logic [31:0] ancestor_set;
    logic [31:0] left_active;
    logic [31:0] right_active;
    logic [15:0] char_weight;
    logic [15:0] char_index;
    logic        last_char;
  } fssp_item_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] result_set;
    logic [31:0] active_set;
    logic [15:0] step_added;
    logic [30:0] total_steps;
    logic [15:0] char_index_out;
    logic        last_out;
  } fssp_result_t;

endpackage

// File: rtl/fitch_state_set_pass_unit.sv
// Fitch state-set pass unit: one character of a tree pass per transaction.
//
//   channel | direction | handshake                    | payload
//   in_     | input     | in_valid / in_ready          | kind, sets, actives, weight, index, last
//   out_    | output    | out_valid / out_ready        | result/active sets, step, total, echoes
//   cfg     | input     | psel/penable/pwrite, pready=1 | register 0: NA state mask
//
// Two stages: an input register, then the set logic and step accumulator feeding
// the result register. One transaction is taken every cycle unless out_ready stalls.
// The running total is the only state linking transactions; it updates as an item
// leaves the input register. Reset (rst_n, synchronous) empties both stages, sets
// the NA mask to 1 and clears the total. A stall on out_ready backs up stage by stage.
module fitch_state_set_pass_unit
  import fssp_pkg::*;
#(
  parameter int STATE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_left_set,
  input  logic [31:0] in_right_set,
  input  logic [31:0] in_node_set,
  input  logic [31:0] in_ancestor_set,
  input  logic [31:0] in_left_active,
  input  logic [31:0] in_right_active,
  input  logic [15:0] in_char_weight,
  input  logic [15:0] in_char_index,
  input  logic        in_last_char,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_set,
  output logic [31:0] out_active_set,
  output logic [15:0] out_step_added,
  output logic [30:0] out_total_steps,
  output logic [15:0] out_char_index_out,
  output logic        out_last_out,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Only the low states are used; wider than the field is clipped to the field
  localparam int SET_W = (STATE_BITS > 32) ? 32 : STATE_BITS;
  localparam logic [31:0] SET_MASK =
    (SET_W == 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SET_W) - 64'd1);

  // Configuration register
  logic [31:0] na_mask_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      na_mask_r <= 32'd1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NA_MASK)) begin
      na_mask_r <= pwdata;
    end
  end

  always_comb begin
    prdata = (paddr[2] == REG_NA_MASK) ? na_mask_r : 32'd0;
  end

  // Pipeline control
  logic         s1_valid_r;
  fssp_item_t   s1_r;
  logic         out_valid_r;
  fssp_result_t res_r;
  fssp_result_t res_nxt;
  logic         s2_ready;
  logic         s2_load;
  logic [30:0]  run_total_r;
  logic [30:0]  run_total_nxt;

  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r.kind         <= in_kind;
      s1_r.left_set     <= in_left_set;
      s1_r.right_set    <= in_right_set;
      s1_r.node_set     <= in_node_set;
      s1_r.ancestor_set <= in_ancestor_set;
      s1_r.left_active  <= in_left_active;
      s1_r.right_active <= in_right_active;
      s1_r.char_weight  <= in_char_weight;
      s1_r.char_index   <= in_char_index;
      s1_r.last_char    <= in_last_char;
    end
  end

  // Masked operands
  logic [31:0] na, ap, l, r, nd, anc, la, ra, lr, lar;
  assign na  = na_mask_r & SET_MASK;
  assign ap  = ~na & SET_MASK;
  assign l   = s1_r.left_set & SET_MASK;
  assign r   = s1_r.right_set & SET_MASK;
  assign nd  = s1_r.node_set & SET_MASK;
  assign anc = s1_r.ancestor_set & SET_MASK;
  assign la  = s1_r.left_active & SET_MASK;
  assign ra  = s1_r.right_active & SET_MASK;
  assign lr  = l | r;
  assign lar = l & r;

  // Set logic for the selected pass
  logic [31:0] res_set;
  logic        step;
  logic        both_ap;
  logic        both_act;

  assign both_ap  = ((l & ap) != 32'd0) && ((r & ap) != 32'd0);
  assign both_act = (la != 32'd0) && (ra != 32'd0);

  always_comb begin
    res_set = 32'd0;
    step    = 1'b0;
    case (s1_r.kind)
      KIND_DOWN: begin
        if (lar == 32'd0) begin
          res_set = lr;
          step    = 1'b1;
        end else begin
          res_set = lar;
        end
      end
      KIND_UP: begin
        if ((anc & nd) == anc)  res_set = anc & nd;
        else if (lar != 32'd0)  res_set = nd | (anc & lr);
        else                    res_set = nd | anc;
      end
      KIND_NA_FIRST_DN: begin
        if (lar == 32'd0)       res_set = both_ap ? (lr & ap) : lr;
        else if (lar == na)     res_set = both_ap ? lr : lar;
        else                    res_set = lar;
      end
      KIND_NA_FIRST_UP: begin
        if ((nd & na) == 32'd0)                          res_set = nd;
        else if (anc == na)                              res_set = na;
        else if ((nd & ap) != 32'd0)                     res_set = nd & ap;
        else if (((lr & ap) != 32'd0) && (lr != SET_MASK)) res_set = lr & ap;
        else                                             res_set = na;
      end
      KIND_NA_SECOND_DN: begin
        if ((nd & ap) == 32'd0) begin
          res_set = nd;
        end else if (lar != 32'd0) begin
          res_set = ((lar & ap) != 32'd0) ? (lar & ap) : lar;
        end else begin
          res_set = lr & ap;
          step    = both_ap || both_act;
        end
      end
      KIND_NA_SECOND_UP: begin
        if ((nd & ap) == 32'd0) begin
          res_set = nd;
          step    = both_act;
        end else if ((anc & ap) == 32'd0) begin
          res_set = nd;
        end else if ((anc & nd) == anc) begin
          res_set = anc;
        end else if (lar != 32'd0) begin
          res_set = nd | (anc & lr);
        end else if ((lr & na) != 32'd0) begin
          res_set = ((lr & anc) != 32'd0) ? anc : ((lr | anc) & ap);
        end else begin
          res_set = nd | anc;
        end
      end
      default: begin
        res_set = 32'd0;
        step    = 1'b0;
      end
    endcase
  end

  // Step accumulation with saturation
  logic [15:0] added;
  logic [31:0] sum;
  logic [30:0] total;

  assign added = step ? s1_r.char_weight : 16'd0;
  assign sum   = {1'b0, run_total_r} + {16'd0, added};
  assign total = sum[31] ? TOTAL_MAX : sum[30:0];

  always_comb begin
    run_total_nxt          = s1_r.last_char ? 31'd0 : total;
    res_nxt.result_set     = res_set;
    res_nxt.active_set     = (la | ra) & ap;
    res_nxt.step_added     = added;
    res_nxt.total_steps    = total;
    res_nxt.char_index_out = s1_r.char_index;
    res_nxt.last_out       = s1_r.last_char;
  end

  // Result register and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_total_r <= 31'd0;
    end else begin
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_load) begin
        run_total_r <= run_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_set     = res_r.result_set;
  assign out_active_set     = res_r.active_set;
  assign out_step_added     = res_r.step_added;
  assign out_total_steps    = res_r.total_steps;
  assign out_char_index_out = res_r.char_index_out;
  assign out_last_out       = res_r.last_out;

`ifndef SYNTHESIS
  // A reported total always covers the weight this character added
  a_total_covers_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, res_r.total_steps} >= {16'd0, res_r.step_added}))
    else $error("total_steps below step_added");

  // The last character of a node pass clears the accumulator
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && s1_r.last_char) |=> (run_total_r == 31'd0))
    else $error("running total not cleared after last character");

  // The accumulator only moves when an item passes into the result register
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_load |=> $stable(run_total_r))
    else $error("running total changed without a transaction");

  // The subtree active set never holds an NA state
  a_active_applicable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.active_set & ~ap) == 32'd0))
    else $error("active set holds a non-applicable state");
`endif

endmodule
